[rtl/core/first_fit_free_list_allocator_top_assert.svh]
// Assertion macros shared by the allocator's RTL.
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FFA_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error("allocator assertion failed");

// Next-cycle implication, checked out of reset.
`define FFA_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error("allocator assertion failed");

`endif

[rtl/core/ffa_pkg.sv]
// Shared constants, status codes and control/status structs of the allocator.
package ffa_pkg;

  localparam int unsigned HEAP_BYTES_DEF = 65536;
  localparam int unsigned ALIGN_BYTES    = 8;
  localparam int unsigned HDR_BYTES      = 16;

  localparam int unsigned REQ_W   = 17;
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned SIZE_W  = 17;
  localparam int unsigned LIMIT_W = 17;
  localparam int unsigned STAT_W  = 3;

  localparam int unsigned LIMIT_RST = 65536;
  localparam int unsigned ADDR_MAX  = 65535;

  localparam logic [STAT_W-1:0] ST_REUSED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_NEW     = 3'd1;
  localparam logic [STAT_W-1:0] ST_OOM     = 3'd2;
  localparam logic [STAT_W-1:0] ST_FREED   = 3'd3;
  localparam logic [STAT_W-1:0] ST_IGNORED = 3'd4;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic walk_init;
    logic walk_step;
    logic take_hit;
    logic take_new;
    logic oom;
    logic free_push;
    logic free_ignore;
  } ffa_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic req_free;
    logic free_ok;
    logic head_nz;
    logic hit;
    logic next_nz;
    logic steps_last;
    logic brk_fits;
  } ffa_sts_t;

endpackage

[rtl/core/ffa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ffa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/ffa_ctrl.sv]
// Request sequencer: decode, free-list walk and break fallback.
module ffa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  ffa_pkg::ffa_sts_t sts,
  output ffa_pkg::ffa_cmd_t cmd
);
  import ffa_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_WALK   = 2'd2;
  localparam logic [1:0] S_BRK    = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.req_free) begin
          cmd.free_push   = sts.free_ok;
          cmd.free_ignore = !sts.free_ok;
          state_nxt       = S_IDLE;
        end else if (sts.head_nz) begin
          cmd.walk_init = 1'b1;
          state_nxt     = S_WALK;
        end else begin
          state_nxt = S_BRK;
        end
      end
      S_WALK: begin
        // header of the current block is on the RAM outputs
        if (sts.hit) begin
          cmd.take_hit = 1'b1;
          state_nxt    = S_IDLE;
        end else if (sts.next_nz && !sts.steps_last) begin
          cmd.walk_step = 1'b1;
        end else begin
          state_nxt = S_BRK;
        end
      end
      S_BRK: begin
        cmd.take_new = sts.brk_fits;
        cmd.oom      = !sts.brk_fits;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

[rtl/core/ffa_dp.sv]
// Allocator datapath: header RAMs, list head, break, limit and result registers.
module ffa_dp #(
  parameter int unsigned HEAP_BYTES = ffa_pkg::HEAP_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ffa_pkg::ffa_cmd_t           cmd,
  output ffa_pkg::ffa_sts_t           sts,
  input  logic                        in_req_type,
  input  logic [ffa_pkg::REQ_W-1:0]   in_req_size,
  input  logic [ffa_pkg::ADDR_W-1:0]  in_free_addr,
  input  logic                        cfg_we,
  input  logic [ffa_pkg::LIMIT_W-1:0] cfg_heap_limit,
  output logic                        out_valid,
  output logic [ffa_pkg::ADDR_W-1:0]  out_result_addr,
  output logic [ffa_pkg::STAT_W-1:0]  out_status
);
  import ffa_pkg::*;

  localparam int unsigned SLOT_COUNT = HEAP_BYTES / 8;
  localparam int unsigned SLOT_W     = $clog2(SLOT_COUNT);
  localparam int unsigned LINK_W     = SLOT_W + 1;
  localparam int unsigned BRK_W      = $clog2(HEAP_BYTES + 1);
  localparam int unsigned NEED_W     = REQ_W + 1;
  localparam int unsigned SUM_W      = ((BRK_W > NEED_W) ? BRK_W : NEED_W) + 1;
  localparam int unsigned AX_W       = ((SLOT_W + 3) > ADDR_W) ? (SLOT_W + 3) : ADDR_W;

  localparam logic [SUM_W-1:0]  HEAP_LIM  = SUM_W'(HEAP_BYTES);
  localparam logic [NEED_W-1:0] ALIGN_MSK = NEED_W'(ALIGN_BYTES - 1);

  logic                req_type_r;
  logic [NEED_W-1:0]   need_r;
  logic [ADDR_W-1:0]   free_addr_r;
  logic [LIMIT_W-1:0]  limit_r;
  logic [LINK_W-1:0]   free_head_r, free_head_nxt;
  logic [BRK_W-1:0]    brk_r, brk_nxt;
  logic [LINK_W-1:0]   cur_r, prev_r;
  logic [LINK_W-1:0]   steps_r;
  logic                out_valid_r;
  logic [ADDR_W-1:0]   out_addr_r, out_addr_nxt;
  logic [STAT_W-1:0]   out_status_r, out_status_nxt;

  logic [SIZE_W-1:0]   size_rd;
  logic [LINK_W-1:0]   link_rd;
  logic [SLOT_W-1:0]   rd_slot;
  logic                size_we;
  logic                link_we;
  logic [SLOT_W-1:0]   link_waddr;
  logic [LINK_W-1:0]   link_wdata;

  logic [LINK_W-1:0]   head_m1, link_m1, prev_m1, cur_m1;
  logic [SLOT_W-1:0]   head_slot, next_slot, prev_slot, cur_slot, brk_slot, free_slot;
  logic [ADDR_W-1:0]   fbase;
  logic [AX_W-1:0]     fbase_x;
  logic [SUM_W-1:0]    lim_ext, lim_eff, brk_hdr, brk_end;
  logic                fin;

  // links hold slot + 1, zero ends the list
  assign head_m1   = free_head_r - LINK_W'(1);
  assign link_m1   = link_rd - LINK_W'(1);
  assign prev_m1   = prev_r - LINK_W'(1);
  assign cur_m1    = cur_r - LINK_W'(1);
  assign head_slot = head_m1[SLOT_W-1:0];
  assign next_slot = link_m1[SLOT_W-1:0];
  assign prev_slot = prev_m1[SLOT_W-1:0];
  assign cur_slot  = cur_m1[SLOT_W-1:0];
  assign brk_slot  = brk_r[SLOT_W+2:3];

  assign fbase     = free_addr_r - ADDR_W'(HDR_BYTES);
  assign fbase_x   = AX_W'(fbase);
  assign free_slot = fbase_x[SLOT_W+2:3];

  assign lim_ext = SUM_W'(limit_r);
  assign lim_eff = (lim_ext < HEAP_LIM) ? lim_ext : HEAP_LIM;
  assign brk_hdr = SUM_W'(brk_r) + SUM_W'(HDR_BYTES);
  assign brk_end = brk_hdr + SUM_W'(need_r);

  always_comb begin
    sts.req_free   = req_type_r;
    sts.free_ok    = (free_addr_r >= ADDR_W'(HDR_BYTES)) && (free_addr_r[2:0] == 3'b000)
                     && (SUM_W'(free_addr_r) <= SUM_W'(brk_r));
    sts.head_nz    = (free_head_r != '0);
    sts.hit        = (NEED_W'(size_rd) >= need_r);
    sts.next_nz    = (link_rd != '0);
    sts.steps_last = (steps_r == LINK_W'(SLOT_COUNT - 1));
    sts.brk_fits   = (brk_end <= lim_eff) && (brk_hdr <= SUM_W'(ADDR_MAX));
  end

  // read port follows the walk: head first, then the link just read
  assign rd_slot = cmd.walk_step ? next_slot : head_slot;

  always_comb begin
    size_we    = cmd.take_new;
    link_we    = cmd.free_push || cmd.take_new || (cmd.take_hit && (prev_r != '0));
    link_waddr = brk_slot;
    link_wdata = '0;
    if (cmd.free_push) begin
      link_waddr = free_slot;
      link_wdata = free_head_r;
    end else if (cmd.take_hit) begin
      link_waddr = prev_slot;
      link_wdata = link_rd;
    end
  end

  ffa_ram #(
    .WIDTH (SIZE_W),
    .DEPTH (SLOT_COUNT)
  ) u_size_ram (
    .clk   (clk),
    .we    (size_we),
    .waddr (brk_slot),
    .wdata (need_r[SIZE_W-1:0]),
    .raddr (rd_slot),
    .rdata (size_rd)
  );

  ffa_ram #(
    .WIDTH (LINK_W),
    .DEPTH (SLOT_COUNT)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (rd_slot),
    .rdata (link_rd)
  );

  always_comb begin
    free_head_nxt = free_head_r;
    if (cmd.free_push) begin
      free_head_nxt = LINK_W'(free_slot) + LINK_W'(1);
    end else if (cmd.take_hit && (prev_r == '0)) begin
      free_head_nxt = link_rd;
    end
  end

  assign brk_nxt = cmd.take_new ? brk_end[BRK_W-1:0] : brk_r;

  assign fin = cmd.take_hit || cmd.take_new || cmd.oom || cmd.free_push || cmd.free_ignore;

  always_comb begin
    out_addr_nxt   = '0;
    out_status_nxt = ST_IGNORED;
    priority if (cmd.take_hit) begin
      out_addr_nxt   = ADDR_W'({cur_slot, 3'b000}) + ADDR_W'(HDR_BYTES);
      out_status_nxt = ST_REUSED;
    end else if (cmd.take_new) begin
      out_addr_nxt   = brk_hdr[ADDR_W-1:0];
      out_status_nxt = ST_NEW;
    end else if (cmd.oom) begin
      out_status_nxt = ST_OOM;
    end else if (cmd.free_push) begin
      out_status_nxt = ST_FREED;
    end else begin
      out_status_nxt = ST_IGNORED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= LIMIT_W'(LIMIT_RST);
      free_head_r <= '0;
      brk_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_heap_limit;
      end
      free_head_r <= free_head_nxt;
      brk_r       <= brk_nxt;
      out_valid_r <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type_r  <= in_req_type;
      need_r      <= (NEED_W'(in_req_size) + ALIGN_MSK) & ~ALIGN_MSK;
      free_addr_r <= in_free_addr;
    end
    if (cmd.walk_init) begin
      cur_r   <= free_head_r;
      prev_r  <= '0;
      steps_r <= '0;
    end else if (cmd.walk_step) begin
      cur_r   <= link_rd;
      prev_r  <= cur_r;
      steps_r <= steps_r + LINK_W'(1);
    end
    if (fin) begin
      out_addr_r   <= out_addr_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_addr = out_addr_r;
  assign out_status      = out_status_r;

endmodule

[rtl/core/first_fit_free_list_allocator_top.sv]
// First-fit free-list heap allocator top. Free: decode forms the result, strobed on out_valid.
// Allocate: decode, then a walk of the free-list headers when the list is not empty (one header
// per cycle through the registered-read size and link RAMs), then the break state when no header fits.
// busy drops as the result is formed; the next request is taken at the edge ending the strobe,
// so a request is taken only once the previous result is out. Reset empties the free list, zeroes
// the break and sets heap_limit to 65536; header RAMs are not cleared. The receiver cannot stall.
`include "first_fit_free_list_allocator_top_assert.svh"
module first_fit_free_list_allocator_top #(
  parameter int unsigned HEAP_BYTES = ffa_pkg::HEAP_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_req_type,
  input  logic [ffa_pkg::REQ_W-1:0]   in_req_size,
  input  logic [ffa_pkg::ADDR_W-1:0]  in_free_addr,
  output logic                        out_valid,
  output logic [ffa_pkg::ADDR_W-1:0]  out_result_addr,
  output logic [ffa_pkg::STAT_W-1:0]  out_status,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ffa_pkg::LIMIT_W-1:0] cfg_heap_limit
);
  import ffa_pkg::*;

  ffa_cmd_t cmd;
  ffa_sts_t sts;
  logic     ctrl_start;

  assign cfg_ready  = 1'b1;
  assign ctrl_start = start && !busy;

  ffa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ctrl_start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  ffa_dp #(
    .HEAP_BYTES (HEAP_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_req_type     (in_req_type),
    .in_req_size     (in_req_size),
    .in_free_addr    (in_free_addr),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_heap_limit  (cfg_heap_limit),
    .out_valid       (out_valid),
    .out_result_addr (out_result_addr),
    .out_status      (out_status)
  );

  `FFA_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `FFA_ASSERT_NXT(a_strobe_single, clk, rst_n, out_valid, !out_valid)
  `FFA_ASSERT_IMP(a_fail_no_addr, clk, rst_n,
    out_valid && ((out_status == ST_OOM) || (out_status == ST_FREED) ||
    (out_status == ST_IGNORED)), out_result_addr == '0)
  `FFA_ASSERT_IMP(a_new_addr, clk, rst_n,
    out_valid && (out_status == ST_NEW), out_result_addr >= ADDR_W'(HDR_BYTES))

endmodule

[bench/first_fit_free_list_allocator_top_test.sv]
// Self-checking testbench for the first-fit free-list allocator top level.
module first_fit_free_list_allocator_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ffa_pkg::*;

  localparam int unsigned SLOTS        = HEAP_BYTES_DEF / ALIGN_BYTES;
  localparam int unsigned PHASE_ITEMS  = 430;
  localparam int unsigned STALL_LIMIT  = 40000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam bit          REQ_ALLOC    = 1'b0;
  localparam bit          REQ_FREE     = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [STAT_W-1:0] status;
  } heap_reply_t;

  class heap_scoreboard;
    bit [SIZE_W-1:0]  block_size [SLOTS];
    bit [13:0]        next_link [SLOTS];
    bit [13:0]        list_head;
    bit [LIMIT_W-1:0] brk;
    bit [LIMIT_W-1:0] limit_value = LIMIT_W'(LIMIT_RST);
    heap_reply_t      pending_replies [$];
    int unsigned      status_count [5];
    int unsigned      mismatches;

    function void set_limit(bit [LIMIT_W-1:0] value);
      limit_value = value;
    endfunction

    function heap_reply_t predict_alloc(bit [REQ_W-1:0] req);
      heap_reply_t r;
      int unsigned need, eff_limit, prev, cur, steps, slot;
      need = (req + ALIGN_BYTES - 1) & ~(ALIGN_BYTES - 1);
      eff_limit = (limit_value < HEAP_BYTES_DEF) ? limit_value : HEAP_BYTES_DEF;
      prev = 0;
      cur = list_head;
      steps = 0;
      // first fit; the step cap stops a looped list
      while (cur != 0 && steps < SLOTS) begin
        slot = (cur - 1) % SLOTS;
        if (block_size[slot] >= need) begin
          if (prev != 0)
            next_link[(prev - 1) % SLOTS] = next_link[slot];
          else
            list_head = next_link[slot];
          r.addr = ADDR_W'(slot * ALIGN_BYTES + HDR_BYTES);
          r.status = ST_REUSED;
          return r;
        end
        prev = cur;
        cur = next_link[slot];
        steps++;
      end
      if (brk + HDR_BYTES + need > eff_limit || brk + HDR_BYTES > ADDR_MAX) begin
        r.addr = '0;
        r.status = ST_OOM;
      end else begin
        slot = (brk / ALIGN_BYTES) % SLOTS;
        block_size[slot] = SIZE_W'(need);
        next_link[slot] = '0;
        r.addr = ADDR_W'(brk + HDR_BYTES);
        r.status = ST_NEW;
        brk = LIMIT_W'(brk + HDR_BYTES + need);
      end
      return r;
    endfunction

    function heap_reply_t predict_free(bit [ADDR_W-1:0] addr);
      heap_reply_t r;
      int unsigned slot;
      r.addr = '0;
      // null falls under the below-header test
      if (addr < HDR_BYTES || addr[2:0] != 3'd0 || addr > brk) begin
        r.status = ST_IGNORED;
      end else begin
        slot = ((addr - HDR_BYTES) / ALIGN_BYTES) % SLOTS;
        next_link[slot] = list_head;
        list_head = 14'(slot + 1);
        r.status = ST_FREED;
      end
      return r;
    endfunction

    function heap_reply_t note_request(bit is_free, bit [REQ_W-1:0] size,
                                       bit [ADDR_W-1:0] faddr);
      heap_reply_t r;
      r = is_free ? predict_free(faddr) : predict_alloc(size);
      pending_replies.push_back(r);
      return r;
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      mismatches++;
    endtask

    task check_result(logic [ADDR_W-1:0] addr, logic [STAT_W-1:0] status);
      heap_reply_t want;
      if (pending_replies.size() == 0) begin
        report_mismatch("result strobe with no request outstanding");
      end else begin
        want = pending_replies.pop_front();
        if (want.status <= ST_IGNORED) status_count[want.status]++;
        if (addr !== want.addr)
          report_mismatch($sformatf("result_addr %0d, expected %0d", addr, want.addr));
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
      end
    endtask
  endclass

  logic                clk;
  logic                rst_n          = 1'b0;
  logic                start          = 1'b0;
  logic                in_req_type    = REQ_ALLOC;
  logic [REQ_W-1:0]    in_req_size    = '0;
  logic [ADDR_W-1:0]   in_free_addr   = '0;
  logic                cfg_valid      = 1'b0;
  logic [LIMIT_W-1:0]  cfg_heap_limit = '0;
  logic                busy;
  logic                out_valid;
  logic                cfg_ready;
  logic [ADDR_W-1:0]   out_result_addr;
  logic [STAT_W-1:0]   out_status;

  heap_scoreboard      sb;
  heap_reply_t         last_reply;
  logic [ADDR_W-1:0]   live_addrs [$];
  int unsigned         idle_pct;
  int unsigned         work_items;
  int unsigned         limit_writes;
  int unsigned         stall_cycles;

  first_fit_free_list_allocator_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_req_size     (in_req_size),
    .in_free_addr    (in_free_addr),
    .out_valid       (out_valid),
    .out_result_addr (out_result_addr),
    .out_status      (out_status),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_heap_limit  (cfg_heap_limit)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) sb.check_result(out_result_addr, out_status);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_request(bit is_free, bit [REQ_W-1:0] size, bit [ADDR_W-1:0] faddr);
    int hit = -1;
    start        <= 1'b1;
    in_req_type  <= is_free;
    in_req_size  <= size;
    in_free_addr <= faddr;
    @(posedge clk);
    while (busy) @(posedge clk);
    last_reply = sb.note_request(is_free, size, faddr);
    if (!is_free && (last_reply.status == ST_REUSED || last_reply.status == ST_NEW))
      live_addrs.push_back(last_reply.addr);
    if (is_free && last_reply.status == ST_FREED) begin
      foreach (live_addrs[i]) if (live_addrs[i] == faddr) hit = i;
      if (hit >= 0) live_addrs.delete(hit);
    end
    if (last_reply.status != ST_IGNORED) work_items++;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // limit changes only with no request in flight
  task automatic program_heap_limit(bit [LIMIT_W-1:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (busy || sb.pending_replies.size() != 0) @(posedge clk);
    cfg_valid      <= 1'b1;
    cfg_heap_limit <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_limit(value);
    limit_writes++;
  endtask

  task automatic random_request();
    int unsigned pick, free_pct, slot, size, faddr;
    pick = $urandom_range(99);
    free_pct = (live_addrs.size() > 48) ? 60 : 35;
    if (live_addrs.size() != 0 && pick < free_pct) begin
      slot = $urandom_range(live_addrs.size() - 1);
      send_request(REQ_FREE, REQ_W'($urandom_range(0, 65536)), live_addrs[slot]);
    end else if (pick >= 94) begin
      // only addresses the block must ignore; a mid-block address would free garbage
      case ($urandom_range(3))
        0: faddr = 0;
        1: faddr = $urandom_range(1, HDR_BYTES - 1);
        2: faddr = $urandom_range(HDR_BYTES, ADDR_MAX) | (1 << $urandom_range(0, 2));
        default: faddr = (sb.brk < ADDR_MAX) ? $urandom_range(sb.brk + 1, ADDR_MAX) : 0;
      endcase
      send_request(REQ_FREE, REQ_W'($urandom_range(0, 65536)), ADDR_W'(faddr));
    end else begin
      pick = $urandom_range(99);
      if (pick < 80)
        size = $urandom_range(0, 128);
      else if (pick < 95)
        size = $urandom_range(0, 2048);
      else
        size = $urandom_range(0, 65536);
      send_request(REQ_ALLOC, REQ_W'(size), ADDR_W'($urandom_range(0, 65535)));
    end
  endtask

  initial begin
    int unsigned target, tight, guard;
    logic [ADDR_W-1:0] loop_addr;
    sb = new();
    idle_pct = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero limit: nothing can grow, bad frees on an empty heap
    program_heap_limit('0);
    send_request(REQ_ALLOC, 0, 16'hFFFF);
    send_request(REQ_ALLOC, 65536, 0);
    send_request(REQ_FREE, 0, 0);
    send_request(REQ_FREE, 17'h1FFFF, 16);

    // oversized limit acts as the full heap
    program_heap_limit({LIMIT_W{1'b1}});
    send_request(REQ_ALLOC, 0, 0);
    send_request(REQ_ALLOC, 1, 0);
    send_request(REQ_ALLOC, 9, 0);
    send_request(REQ_ALLOC, 65536, 0);
    send_request(REQ_FREE, 0, 8);
    send_request(REQ_FREE, 0, 20);
    send_request(REQ_FREE, 0, 80);
    send_request(REQ_FREE, 0, 32);
    send_request(REQ_FREE, 0, 16);
    send_request(REQ_ALLOC, 8, 0);        // skips the zero-size head, unlinks second
    send_request(REQ_ALLOC, 0, 0);        // takes the head
    send_request(REQ_ALLOC, 7, 0);
    send_request(REQ_FREE, 0, 56);
    send_request(REQ_ALLOC, 17, 0);       // too big for the free block, new space
    send_request(REQ_ALLOC, 16, 0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct = 0;
          program_heap_limit({LIMIT_W{1'b1}});
        end
        1: begin
          idle_pct = 57;
          program_heap_limit(LIMIT_W'(LIMIT_RST));
        end
        2: begin
          idle_pct = 0;
          tight = sb.brk + HDR_BYTES + ALIGN_BYTES * $urandom_range(0, 1024);
          program_heap_limit(LIMIT_W'((tight > LIMIT_RST) ? LIMIT_RST : tight));
        end
        default: begin
          idle_pct = 11;
          program_heap_limit('0);
        end
      endcase
      target = work_items + PHASE_ITEMS;
      while (work_items < target) random_request();
    end

    idle_pct = 0;
    program_heap_limit(LIMIT_W'(LIMIT_RST));
    // empty the free list: a zero-byte request always takes the head
    guard = 0;
    do begin
      send_request(REQ_ALLOC, 0, 0);
      guard++;
    end while (last_reply.status == ST_REUSED && guard < SLOTS);
    // land the break where the next header fits the limit but its address overflows 16 bits
    if (sb.brk <= HEAP_BYTES_DEF - 2 * HDR_BYTES)
      send_request(REQ_ALLOC, REQ_W'(HEAP_BYTES_DEF - 2 * HDR_BYTES - sb.brk), 0);
    send_request(REQ_ALLOC, 0, 0);

    if (live_addrs.size() != 0) begin
      loop_addr = live_addrs[live_addrs.size() - 1];
      send_request(REQ_FREE, 0, loop_addr);
      send_request(REQ_FREE, 0, loop_addr);    // block now links to itself
      send_request(REQ_ALLOC, 65536, 0);       // walk hits the step cap
      send_request(REQ_ALLOC, 0, 0);
    end

    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d allocator results: %0d reused, %0d new, %0d out of memory,",
             sb.status_count[0] + sb.status_count[1] + sb.status_count[2] +
             sb.status_count[3] + sb.status_count[4],
             sb.status_count[ST_REUSED], sb.status_count[ST_NEW], sb.status_count[ST_OOM]);
    $display("%0d freed, %0d ignored; %0d heap limit writes incl. zero, tight and oversized",
             sb.status_count[ST_FREED], sb.status_count[ST_IGNORED], limit_writes);
    if (sb.mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
